// ----- rtl/usm_pkg.sv -----
package usm_pkg;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int W_W        = 11;
  localparam int H_W        = 16;
  localparam int HALF_W     = 2;
  localparam int AMT_W      = 12;
  localparam int WGT_W      = 48;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 32;
  localparam int Q_W        = 27;
  localparam int DLY_W      = 13;
  localparam int CFG_ADDR_W = 3;

  // Default build sizes
  localparam int MAX_LINE_DEF = 1024;
  localparam int MAX_HALF_DEF = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_HALF    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_MODE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHARPEN_AMOUNT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHTS_NEAR   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHTS_FAR    = 3'd6;

  // Pick a coefficient by the distance class of a tap
  function automatic logic [COEF_W-1:0] tap_weight(input logic [2:0] a, input logic [2:0] b,
                                                   input logic [WGT_W-1:0] near,
                                                   input logic [WGT_W-1:0] far);
    logic [2:0] lo;
    logic [2:0] hi;
    logic [3:0] sum;
    logic [COEF_W-1:0] w;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    sum = {1'b0, lo} + {1'b0, hi};
    if (hi < 3'd2) begin
      case (sum)
        4'd0:    w = near[15:0];
        4'd1:    w = near[31:16];
        default: w = near[47:32];
      endcase
    end else begin
      case (lo)
        3'd0:    w = far[15:0];
        3'd1:    w = far[31:16];
        default: w = far[47:32];
      endcase
    end
    return w;
  endfunction

endpackage

// ----- rtl/usm_div.sv -----
module usm_div #(
  parameter int N_W = usm_pkg::Q_W,
  parameter int D_W = usm_pkg::W_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quot,
  output logic [D_W-1:0] rem
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     trial;
  logic             trial_ge;

  // One quotient bit per cycle, restoring
  assign trial    = {rem, quot[N_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend through, build quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[N_W-2:0], trial_ge};
      rem  <= trial_ge ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
    end
  end

endmodule

// ----- rtl/unsharp_mask_sharpener_core.sv -----
// Unsharp-mask sharpener: grey 8-bit pixels enter in raster order, followed by drain beats
// that push out the tail of the frame. Each beat writes one line-store entry; the result for
// pixel q leaves on the beat at stream position q + half*width + half. For a beat that yields a
// result, a serial divider splits the position into row and column, then the window is read
// from the single-read-port line store one tap per cycle and accumulated through a multiplier.
// The result sits in an output register, so the next beat is taken while it waits. Mode 0
// gives the weighted blur, mode 1 original + amount/256*(original - blur), clamped to 0..255.
// The line store is not cleared at reset; configure only between beats.
module unsharp_mask_sharpener_core #(
  parameter int MAX_LINE = usm_pkg::MAX_LINE_DEF,
  parameter int MAX_HALF = usm_pkg::MAX_HALF_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [usm_pkg::PIX_W-1:0]       s_tdata,   // pixel_in
  input  logic                            s_tuser,   // drain
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [usm_pkg::PIX_W-1:0]       m_tdata,   // pixel_out
  output logic                            m_tlast,   // frame_end
  input  logic                            cfg_we,
  input  logic [usm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [usm_pkg::WGT_W-1:0]       cfg_data
);
  import usm_pkg::*;

  localparam int SIDE   = 2 * MAX_HALF + 1;
  localparam int DEPTH  = SIDE * MAX_LINE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(SIDE);
  localparam int ACC_W  = PIX_W + COEF_W + 5;
  localparam int PROD_W = PIX_W + COEF_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_TAPS  = 3'd3;
  localparam logic [2:0] S_WAIT1 = 3'd4;
  localparam logic [2:0] S_WAIT2 = 3'd5;
  localparam logic [2:0] S_MIX   = 3'd6;

  // Configuration registers
  logic [W_W-1:0]          frame_width;
  logic [H_W-1:0]          frame_height;
  logic [HALF_W-1:0]       kernel_half;
  logic                    output_mode;
  logic signed [AMT_W-1:0] sharpen_amount;
  logic [WGT_W-1:0]        weights_near;
  logic [WGT_W-1:0]        weights_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= W_W'(1024);
      frame_height   <= H_W'(1);
      kernel_half    <= HALF_W'(1);
      output_mode    <= 1'b1;
      sharpen_amount <= AMT_W'(256);
      weights_near   <= '0;
      weights_far    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[W_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[H_W-1:0];
        CFG_KERNEL_HALF:    kernel_half    <= cfg_data[HALF_W-1:0];
        CFG_OUTPUT_MODE:    output_mode    <= cfg_data[0];
        CFG_SHARPEN_AMOUNT: sharpen_amount <= cfg_data[AMT_W-1:0];
        CFG_WEIGHTS_NEAR:   weights_near   <= cfg_data;
        CFG_WEIGHTS_FAR:    weights_far    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame geometry
  logic [W_W-1:0]    w_eff;
  logic [H_W-1:0]    h_eff;
  logic [HALF_W-1:0] half_eff;
  logic [DLY_W-1:0]  delay;
  logic [Q_W-1:0]    total;
  logic [POS_W-1:0]  q_full;
  logic [ADDR_W-1:0] two_dly;

  always_comb begin
    if (frame_width == '0)
      w_eff = W_W'(1);
    else if ({3'b0, frame_width} > 14'(MAX_LINE))
      w_eff = W_W'(MAX_LINE);
    else
      w_eff = frame_width;
    h_eff    = (frame_height == '0) ? H_W'(1) : frame_height;
    half_eff = (kernel_half > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : kernel_half;
    delay    = DLY_W'(half_eff) * DLY_W'(w_eff) + DLY_W'(half_eff);
    total    = Q_W'(w_eff) * Q_W'(h_eff);
    two_dly  = ADDR_W'({delay, 1'b0});
  end

  // Control state
  logic [2:0]        state;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] wr_ptr_next;
  logic              last_r;
  logic [H_W-1:0]    row_r;
  logic [W_W-1:0]    col_r;
  logic [IDX_W-1:0]  ti;
  logic [IDX_W-1:0]  tj;
  logic [ADDR_W-1:0] row_addr;
  logic [ADDR_W-1:0] tap_addr;
  logic              out_load;

  assign q_full      = pos - POS_W'(delay);
  assign wr_ptr_next = (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign s_tready    = (state == S_IDLE);
  assign out_load    = (state == S_MIX) && (!m_tvalid || m_tready);

  // Serial divider: row and column of the output pixel
  logic           div_start;
  logic           div_done;
  logic [Q_W-1:0] div_quot;
  logic [W_W-1:0] div_rem;

  assign div_start = (state == S_CHECK) && (pos >= POS_W'(delay)) &&
                     (q_full < POS_W'(total));

  usm_div #(.N_W(Q_W), .D_W(W_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_full[Q_W-1:0]),
    .divisor  (w_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Tap addressing and bounds
  logic [ADDR_W:0]   start_wrap;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W:0]   row_sum;
  logic [ADDR_W-1:0] row_next;
  logic [ADDR_W-1:0] col_next;
  logic [IDX_W-1:0]  last_idx;
  logic [H_W:0]      rr;
  logic [W_W:0]      cc;
  logic              tap_inb;
  logic [IDX_W-1:0]  da;
  logic [IDX_W-1:0]  db;
  logic              tap_ctr;
  logic [COEF_W-1:0] tap_w;

  always_comb begin
    start_wrap = {1'b0, wr_ptr} + (ADDR_W + 1)'(DEPTH) - {1'b0, two_dly};
    start_addr = (wr_ptr >= two_dly) ? wr_ptr - two_dly : start_wrap[ADDR_W-1:0];
    row_sum    = {1'b0, row_addr} + (ADDR_W + 1)'(w_eff);
    row_next   = (row_sum >= (ADDR_W + 1)'(DEPTH)) ?
                 ADDR_W'(row_sum - (ADDR_W + 1)'(DEPTH)) : row_sum[ADDR_W-1:0];
    col_next   = (tap_addr == ADDR_W'(DEPTH - 1)) ? '0 : tap_addr + 1'b1;
    last_idx   = IDX_W'({half_eff, 1'b0});
    rr         = {1'b0, row_r} + (H_W + 1)'(ti);
    cc         = {1'b0, col_r} + (W_W + 1)'(tj);
    tap_inb    = (rr >= (H_W + 1)'(half_eff)) &&
                 (rr < {1'b0, h_eff} + (H_W + 1)'(half_eff)) &&
                 (cc >= (W_W + 1)'(half_eff)) &&
                 (cc < {1'b0, w_eff} + (W_W + 1)'(half_eff));
    da         = (ti >= IDX_W'(half_eff)) ? ti - IDX_W'(half_eff) : IDX_W'(half_eff) - ti;
    db         = (tj >= IDX_W'(half_eff)) ? tj - IDX_W'(half_eff) : IDX_W'(half_eff) - tj;
    tap_ctr    = (ti == IDX_W'(half_eff)) && (tj == IDX_W'(half_eff));
    tap_w      = tap_weight(3'(da), 3'(db), weights_near, weights_far);
  end

  // Line store: write on the accepted beat, read one tap a cycle
  logic [PIX_W-1:0] line_mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic             accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept)
      line_mem[wr_ptr] <= s_tuser ? '0 : s_tdata;
    rd_data <= line_mem[tap_addr];
  end

  // Tap pipeline: read, multiply, accumulate
  logic              s1_valid;
  logic              s1_inb;
  logic              s1_ctr;
  logic [COEF_W-1:0] s1_w;
  logic              s2_valid;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  orig;
  logic [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_TAPS);
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_inb <= tap_inb;
    s1_ctr <= tap_ctr;
    s1_w   <= tap_w;
    prod   <= s1_inb ? rd_data * s1_w : '0;
    if (s1_valid && s1_ctr)
      orig <= rd_data;
    if (div_done)
      acc <= '0;
    else if (s2_valid)
      acc <= acc + ACC_W'(prod);
  end

  // Blur and sharpen
  logic [ACC_W-COEF_W-1:0] blur_full;
  logic [PIX_W-1:0]        blur;
  logic signed [9:0]       diff;
  logic signed [21:0]      gain_prod;
  logic signed [22:0]      mix_v;
  logic [PIX_W-1:0]        sharp;
  logic [PIX_W-1:0]        result;

  always_comb begin
    blur_full = acc[ACC_W-1:COEF_W];
    blur      = (blur_full > (ACC_W - COEF_W)'(PIX_MAX)) ? PIX_MAX : blur_full[PIX_W-1:0];
    diff      = $signed({2'b0, orig}) - $signed({2'b0, blur});
    gain_prod = sharpen_amount * diff;
    mix_v     = $signed({7'b0, orig, 8'b0}) + $signed({gain_prod[21], gain_prod});
    if (mix_v[22])
      sharp = '0;
    else if (mix_v[21:16] != '0)
      sharp = PIX_MAX;
    else
      sharp = mix_v[15:8];
    result = output_mode ? sharp : blur;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      wr_ptr   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Hold the result beat until it is taken
      if (out_load)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept)
            state <= S_CHECK;
        end
        S_CHECK: begin
          if (pos < POS_W'(delay)) begin
            pos    <= pos + 1'b1;
            wr_ptr <= wr_ptr_next;
            state  <= S_IDLE;
          end else if (q_full >= POS_W'(total)) begin
            pos    <= '0;
            wr_ptr <= '0;
            state  <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done)
            state <= S_TAPS;
        end
        S_TAPS: begin
          if (tj == last_idx && ti == last_idx)
            state <= S_WAIT1;
        end
        S_WAIT1: state <= S_WAIT2;
        S_WAIT2: state <= S_MIX;
        S_MIX: begin
          if (out_load) begin
            if (last_r) begin
              pos    <= '0;
              wr_ptr <= '0;
            end else begin
              pos    <= pos + 1'b1;
              wr_ptr <= wr_ptr_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item payload: position split, window walk, result
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      last_r   <= (q_full == POS_W'(total - 1'b1));
      row_addr <= start_addr;
      tap_addr <= start_addr;
    end
    if (div_done) begin
      row_r <= div_quot[H_W-1:0];
      col_r <= div_rem;
      ti    <= '0;
      tj    <= '0;
    end
    if (state == S_TAPS) begin
      if (tj == last_idx) begin
        tj       <= '0;
        ti       <= ti + 1'b1;
        row_addr <= row_next;
        tap_addr <= row_next;
      end else begin
        tj       <= tj + 1'b1;
        tap_addr <= col_next;
      end
    end
    if (out_load) begin
      m_tdata <= result;
      m_tlast <= last_r;
    end
  end

endmodule
